### rtl/ttmc_pkg.sv
// Shared types and constants for the tolerance template match classifier.
`default_nettype none
package ttmc_pkg;

    localparam int NUM_CASES_DEF = 2;
    localparam int GRID_ROWS_DEF = 32;
    localparam int GRID_COLS_DEF = 32;

    localparam int CASE_W  = 3;
    localparam int COORD_W = 5;
    localparam int VALUE_W = 12;
    localparam int COUNT_W = 11;
    localparam int PCT_W   = 7;

    localparam logic [PCT_W-1:0]   TOL_RESET = PCT_W'(25);
    localparam int                 PERCENT_DIV = 100;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // floor(x / 100) as (x * RECIP) >> DIV_SHIFT, exact for x below 2^20
    localparam int PROD_W    = VALUE_W + PCT_W;
    localparam int TOL_W     = 13;
    localparam int DIV_SHIFT = 26;
    localparam int RECIP_W   = 20;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + PERCENT_DIV - 1) / PERCENT_DIV);

    // signed width that holds value - tol and value + tol
    localparam int CMP_W = 15;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CASE_W-1:0]  case_index;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [CASE_W-1:0]  best_case;
        logic [COUNT_W-1:0] best_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_TOL,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

### rtl/tolerance_template_match_classifier_unit.sv
// Top level: template store, per-case match counters and best-case selection.
//
// Input channel s_valid/s_ready/s_data carries load and sample transactions.
// A load writes one template value into the store and leaves the block ready.
// A sample is compared against the template of every case at its cell:
// after acceptance state ST_PROD forms sample*tolerance, ST_TOL divides by 100,
// then each case passes ST_READ and ST_CMP on the single template memory port (read,
// then compare and count). While a sample is in these states the block is
// busy and accepts no new transaction.
// A sample marked last then enters ST_EMIT, which loads the result register
// once it is free; the result (best_case, best_count) appears on m_data with
// m_valid the cycle after that load, and the counters clear at that point.
// A result waits in the output register while m_ready is low; samples that
// are not last keep being accepted, and a further last sample waits until
// the pending result is taken.
// cfg_wr_en/cfg_wr_data write the tolerance percent, reset value 25.
// Reset clears the counters and the output valid and sets the tolerance to 25;
// the template store is not cleared and must be loaded before use.
`default_nettype none
module tolerance_template_match_classifier_unit #(
    parameter int NUM_CASES = ttmc_pkg::NUM_CASES_DEF,
    parameter int GRID_ROWS = ttmc_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = ttmc_pkg::GRID_COLS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  ttmc_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output ttmc_pkg::out_item_t          m_data,
    input  wire                          cfg_wr_en,
    input  wire [ttmc_pkg::PCT_W-1:0]    cfg_wr_data
);
    import ttmc_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int DEPTH = NUM_CASES * CELLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (NUM_CASES > 1) ? $clog2(NUM_CASES) : 1;
    localparam logic [CW-1:0] LAST_CASE = CW'(NUM_CASES - 1);

    // template store
    logic [VALUE_W-1:0] mem [DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_data.value;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    state_t              state_reg, state_next;
    logic [PCT_W-1:0]    pct_reg, pct_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                last_reg, last_next;
    logic                grid_reg, grid_next;
    logic [AW-1:0]       cell_reg, cell_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TOL_W-1:0]    tol_reg, tol_next;
    logic [CW-1:0]       case_reg, case_next;
    logic [COUNT_W-1:0]  cnt_reg [NUM_CASES];
    logic [COUNT_W-1:0]  cnt_next [NUM_CASES];
    logic [CW-1:0]       best_reg, best_next;
    logic [COUNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic                      in_grid;
    logic                      case_ok;
    logic [AW-1:0]             in_cell;
    logic [PROD_W+RECIP_W-1:0] div_full;
    logic signed [CMP_W-1:0]   lo_bound, hi_bound, tmpl;
    logic                      hit;
    logic [COUNT_W-1:0]        cnt_cur, cnt_upd;

    always_comb begin
        in_grid  = (int'(s_data.row) < GRID_ROWS) && (int'(s_data.col) < GRID_COLS);
        case_ok  = int'(s_data.case_index) < NUM_CASES;
        in_cell  = in_grid ? AW'(int'(s_data.row) * GRID_COLS + int'(s_data.col)) : '0;
        div_full = prod_reg * RECIP;
        lo_bound = signed'(CMP_W'(val_reg) - CMP_W'(tol_reg));
        hi_bound = signed'(CMP_W'(val_reg) + CMP_W'(tol_reg));
        tmpl     = signed'(CMP_W'(rd_data_reg));
        hit      = grid_reg && (lo_bound < tmpl) && (tmpl < hi_bound);
        cnt_cur  = cnt_reg[case_reg];
        cnt_upd  = (hit && (cnt_cur != COUNT_MAX)) ? cnt_cur + COUNT_W'(1) : cnt_cur;
    end

    always_comb begin
        state_next    = state_reg;
        pct_next      = cfg_wr_en ? cfg_wr_data : pct_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        grid_next     = grid_reg;
        cell_next     = cell_reg;
        prod_next     = prod_reg;
        tol_next      = tol_reg;
        case_next     = case_reg;
        cnt_next      = cnt_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        s_ready       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = AW'(int'(s_data.case_index) * CELLS) + in_cell;
        mem_raddr     = AW'(int'(case_reg) * CELLS) + cell_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.op == OP_LOAD) begin
                        mem_we = in_grid && case_ok;
                    end else begin
                        val_next   = s_data.value;
                        last_next  = s_data.last;
                        grid_next  = in_grid;
                        cell_next  = in_cell;
                        case_next  = '0;
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD: begin
                prod_next  = val_reg * pct_reg;
                state_next = ST_TOL;
            end
            ST_TOL: begin
                tol_next   = TOL_W'(div_full >> DIV_SHIFT);
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cnt_next[case_reg] = cnt_upd;
                // running maximum; strict compare keeps the lower index on ties
                if (case_reg == '0 || cnt_upd > best_cnt_reg) begin
                    best_next     = case_reg;
                    best_cnt_next = cnt_upd;
                end
                if (case_reg == LAST_CASE) begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    case_next  = case_reg + CW'(1);
                    state_next = ST_READ;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.best_case  = CASE_W'(best_reg);
                    m_data_next.best_count = best_cnt_reg;
                    for (int i = 0; i < NUM_CASES; i++) begin
                        cnt_next[i] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pct_reg     <= TOL_RESET;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CASES; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            pct_reg     <= pct_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg      <= val_next;
        last_reg     <= last_next;
        grid_reg     <= grid_next;
        cell_reg     <= cell_next;
        prod_reg     <= prod_next;
        tol_reg      <= tol_next;
        case_reg     <= case_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

### sim/tb_tolerance_template_match_classifier_unit.sv
// Self-checking testbench for the tolerance template match classifier unit.
`default_nettype none
module tb_tolerance_template_match_classifier_unit;
    import ttmc_pkg::*;

    localparam int NCASES       = NUM_CASES_DEF;
    localparam int CELLS        = GRID_ROWS_DEF * GRID_COLS_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int SETTLE       = 16;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DIR_ROWS     = 19;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

    typedef struct packed {
        op_t                op;
        logic [CASE_W-1:0]  cs;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               typed;
        logic [CASE_W-1:0]  t_case;
        logic [COUNT_W-1:0] t_count;
    } dir_row_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    in_item_t           s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    out_item_t          m_data;
    logic               cfg_wr_en   = 1'b0;
    logic [PCT_W-1:0]   cfg_wr_data = '0;

    tolerance_template_match_classifier_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic [VALUE_W-1:0] tmpl_mem [NCASES*CELLS];
    logic [COUNT_W-1:0] hit_count [NCASES] = '{default: '0};
    logic [PCT_W-1:0]   tol_pct = TOL_RESET;
    out_item_t          expected_results [$];
    int                 acc_count     = 0;
    int                 results_seen  = 0;
    int                 error_count   = 0;

    // typed-in expectation for the directed row in flight
    logic               typed_on  = 1'b0;
    out_item_t          typed_res = '0;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge aclk) begin : scoreboard
        out_item_t want;
        int        cidx, smp, tv, tl, best_c, best_n;
        bit        in_grid;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result case=%0d count=%0d",
                                              m_data.best_case, m_data.best_count));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.best_case !== want.best_case)
                        report_mismatch($sformatf("best_case got %0d exp %0d",
                                                  m_data.best_case, want.best_case));
                    if (m_data.best_count !== want.best_count)
                        report_mismatch($sformatf("best_count got %0d exp %0d",
                                                  m_data.best_count, want.best_count));
                end
            end
            if (cfg_wr_en)
                tol_pct = cfg_wr_data;
            if (s_valid && s_ready) begin
                acc_count <= acc_count + 1;
                in_grid = (int'(s_data.row) < GRID_ROWS_DEF) && (int'(s_data.col) < GRID_COLS_DEF);
                cidx = int'(s_data.row) * GRID_COLS_DEF + int'(s_data.col);
                if (s_data.op == OP_LOAD) begin
                    if (in_grid && int'(s_data.case_index) < NCASES)
                        tmpl_mem[int'(s_data.case_index) * CELLS + cidx] = s_data.value;
                end else begin
                    smp = int'(s_data.value);
                    tl  = (smp * int'(tol_pct)) / PERCENT_DIV;
                    if (in_grid) begin
                        for (int c = 0; c < NCASES; c++) begin
                            tv = int'(tmpl_mem[c * CELLS + cidx]);
                            if ((smp - tl < tv) && (tv < smp + tl) && hit_count[c] < COUNT_MAX)
                                hit_count[c] = hit_count[c] + 1'b1;
                        end
                    end
                    if (s_data.last) begin
                        best_c = 0;
                        best_n = 0;
                        for (int c = 0; c < NCASES; c++) begin
                            if (int'(hit_count[c]) > best_n) begin
                                best_n = int'(hit_count[c]);
                                best_c = c;
                            end
                        end
                        want.best_case  = CASE_W'(best_c);
                        want.best_count = COUNT_W'(best_n);
                        expected_results.push_back(typed_on ? typed_res : want);
                        for (int c = 0; c < NCASES; c++)
                            hit_count[c] = '0;
                    end
                end
            end
        end
    end

    // receiver: back-pressure pattern whose mode is redrawn at random
    rx_mode_t rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FREE:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_ready <= (rx_tick % 7 == 0);
            default:   m_ready <= (rx_left < 4);   // long stall, short release
        endcase
    end

    // stimulus-side knowledge of the template store, so samples only hit loaded cells
    logic [VALUE_W-1:0] gen_tmpl [NCASES][CELLS];
    bit                 gen_set [NCASES][CELLS];
    bit                 gen_ready [CELLS];
    int                 ready_cells [$];
    int                 burst_left = 0;

    function automatic in_item_t mk_item(op_t op, int cs, int r, int c, int v, bit last);
        in_item_t it;
        it.op         = op;
        it.case_index = CASE_W'(cs);
        it.row        = COORD_W'(r);
        it.col        = COORD_W'(c);
        it.value      = VALUE_W'(v);
        it.last       = last;
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(in_item_t it);
        int  gap, cidx, target;
        bit  all_set;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
                0:       gap = 0;
                1, 2, 3: gap = $urandom_range(1, 3);
                default: gap = $urandom_range(4, 12);
            endcase
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        if (it.op == OP_LOAD && int'(it.case_index) < NCASES &&
            int'(it.row) < GRID_ROWS_DEF && int'(it.col) < GRID_COLS_DEF) begin
            cidx = int'(it.row) * GRID_COLS_DEF + int'(it.col);
            gen_tmpl[it.case_index][cidx] = it.value;
            gen_set[it.case_index][cidx]  = 1'b1;
            if (!gen_ready[cidx]) begin
                all_set = 1'b1;
                for (int c = 0; c < NCASES; c++)
                    all_set &= gen_set[c][cidx];
                if (all_set) begin
                    gen_ready[cidx] = 1'b1;
                    ready_cells.push_back(cidx);
                end
            end
        end
        target = acc_count + 1;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(negedge aclk); while (acc_count != target);
        burst_left--;
    endtask

    // hold the sender until every result is in and the pipeline has emptied
    task automatic drain(int extra);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic set_tolerance(int pct);
        cfg_wr_data <= PCT_W'(pct);
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    dir_row_t directed_tbl [DIR_ROWS] = '{
        // all-zero template, zero sample: tolerance is 0 so nothing matches
        '{OP_LOAD,   3'd0, 5'd0,  5'd0,  12'd0,    1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_LOAD,   3'd1, 5'd0,  5'd0,  12'd0,    1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd0,  5'd0,  12'd0,    1'b1, 1'b1, 3'd0, 11'd0},
        // full-scale corner, both cases tie, lower index wins
        '{OP_LOAD,   3'd0, 5'd31, 5'd31, 12'd4095, 1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_LOAD,   3'd1, 5'd31, 5'd31, 12'd4095, 1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd31, 5'd31, 12'd4095, 1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd31, 5'd31, 12'd4095, 1'b1, 1'b1, 3'd0, 11'd2},
        // loads to nonexistent cases are dropped, last on a load does nothing
        '{OP_LOAD,   3'd7, 5'd31, 5'd31, 12'd0,    1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_LOAD,   3'd2, 5'd31, 5'd31, 12'd0,    1'b1, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd31, 5'd31, 12'd4095, 1'b1, 1'b1, 3'd0, 11'd1},
        // window edges: sample 100, tol 25 -> 125 misses, 76 hits
        '{OP_LOAD,   3'd0, 5'd1,  5'd2,  12'd125,  1'b1, 1'b0, 3'd0, 11'd0},
        '{OP_LOAD,   3'd1, 5'd1,  5'd2,  12'd76,   1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd1,  5'd2,  12'd100,  1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd1,  5'd2,  12'd100,  1'b1, 1'b0, 3'd0, 11'd0},
        '{OP_LOAD,   3'd0, 5'd16, 5'd21, 12'd1000, 1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_LOAD,   3'd1, 5'd16, 5'd21, 12'd1300, 1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd16, 5'd21, 12'd1200, 1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd16, 5'd21, 12'd1100, 1'b0, 1'b0, 3'd0, 11'd0},
        '{OP_SAMPLE, 3'd0, 5'd0,  5'd0,  12'd4095, 1'b1, 1'b0, 3'd0, 11'd0}
    };

    initial begin : stimulus
        int rand_items, frame_no, tol_writes, n_new, flen, r, c, base, cidx, tv, sv, pick;
        int tol_plan [$];
        rand_items = 0;
        frame_no   = 0;
        tol_writes = 0;
        tol_plan   = '{0, 127, 100, 1, 99, 50};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            typed_on         = directed_tbl[i].typed;
            typed_res.best_case  = directed_tbl[i].t_case;
            typed_res.best_count = directed_tbl[i].t_count;
            send_item(mk_item(directed_tbl[i].op, int'(directed_tbl[i].cs),
                              int'(directed_tbl[i].row), int'(directed_tbl[i].col),
                              int'(directed_tbl[i].value), directed_tbl[i].last));
        end
        typed_on = 1'b0;

        while (rand_items < RANDOM_ITEMS) begin
            if (frame_no % 6 == 0) begin
                drain(SETTLE);
                set_tolerance(tol_plan.size() != 0 ? tol_plan.pop_front()
                                                   : int'($urandom_range(0, 127)));
                tol_writes++;
            end else if (frame_no % 6 == 3 && $urandom_range(0, 1)) begin
                drain(SETTLE);
            end

            n_new = $urandom_range(0, ready_cells.size() < 8 ? 4 : 2);
            for (int k = 0; k < n_new; k++) begin
                r    = $urandom_range(0, GRID_ROWS_DEF - 1);
                c    = $urandom_range(0, GRID_COLS_DEF - 1);
                base = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 4095 : 0)
                                                 : int'($urandom_range(0, 4095));
                for (int cs = 0; cs < NCASES; cs++) begin
                    tv = base + int'($urandom_range(0, 600)) - 300;
                    if ($urandom_range(0, 4) == 0)
                        tv = $urandom_range(0, 4095);
                    tv = tv < 0 ? 0 : (tv > 4095 ? 4095 : tv);
                    send_item(mk_item(OP_LOAD, cs, r, c, tv, $urandom_range(0, 7) == 0));
                    rand_items++;
                end
            end

            // noise: writes to cases that do not exist are dropped by the block
            if ($urandom_range(0, 9) == 0)
                send_item(mk_item(OP_LOAD, $urandom_range(NCASES, 7),
                                  $urandom_range(0, 31), $urandom_range(0, 31),
                                  $urandom_range(0, 4095), $urandom_range(0, 1)));

            flen = $urandom_range(0, 4) == 0 ? 1 : int'($urandom_range(2, 12));
            for (int k = 0; k < flen; k++) begin
                cidx = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
                tv   = int'(gen_tmpl[$urandom_range(0, NCASES - 1)][cidx]);
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    sv = tv + int'($urandom_range(0, 400)) - 200;
                else if (pick < 17)
                    sv = $urandom_range(0, 4095);
                else
                    sv = (pick == 17) ? 0 : 4095;
                sv = sv < 0 ? 0 : (sv > 4095 ? 4095 : sv);
                send_item(mk_item(OP_SAMPLE, $urandom_range(0, 7), cidx / GRID_COLS_DEF,
                                  cidx % GRID_COLS_DEF, sv, k == flen - 1));
                rand_items++;
            end
            frame_no++;
        end

        drain(SETTLE);
        $display("Run: %0d transactions accepted, %0d frames, %0d results checked",
                 acc_count, frame_no, results_seen);
        $display("Covered %0d tolerance settings incl. 0/100/127, ties and window edges",
                 tol_writes);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(4 * LIMIT_CYCLES);
        $display("Timeout: %0d results still outstanding", expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

### tolerance_template_match_classifier_unit.f
rtl/ttmc_pkg.sv
rtl/tolerance_template_match_classifier_unit.sv
sim/tb_tolerance_template_match_classifier_unit.sv
